// ----- design/fts_pkg.sv -----
// fts_pkg: shared widths, reset values, codes and structs of the frame timing statistics unit
// no dependencies; used by every other file through scoped names
package fts_pkg;

  localparam int TIME_BITS      = 32;
  localparam int COUNT_BITS     = 16;
  localparam int SLEEP_BITS     = 16;
  localparam int THRESH_BITS    = 32;
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_IDX_BITS   = 2;
  localparam int SUM_BITS       = TIME_BITS + COUNT_BITS;
  localparam int SLEEP_SUM_BITS = SLEEP_BITS + COUNT_BITS;
  localparam int STEP_BITS      = $clog2(SUM_BITS);

  localparam logic [COUNT_BITS-1:0]  FLUSH_RESET  = COUNT_BITS'(600);
  localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(500);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FLUSH  = 2'd0,
    CFG_THRESH = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MEAN_PRE   = 2'd0,
    MEAN_FINAL = 2'd1,
    MEAN_SLEEP = 2'd2,
    MEAN_OVER  = 2'd3
  } mean_sel_e;

  typedef struct packed {
    logic [TIME_BITS-1:0]  pre_elapsed;
    logic [TIME_BITS-1:0]  final_elapsed;
    logic [SLEEP_BITS-1:0] slept_ms;
    logic [TIME_BITS-1:0]  target_interval;
  } fts_frame_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] frames_seen;
    logic [COUNT_BITS-1:0] frames_slept;
    logic [COUNT_BITS-1:0] frames_late;
    logic [TIME_BITS-1:0]  mean_pre;
    logic [TIME_BITS-1:0]  mean_final;
    logic [TIME_BITS-1:0]  least_final;
    logic [TIME_BITS-1:0]  most_final;
    logic [SLEEP_BITS-1:0] mean_sleep;
    logic [TIME_BITS-1:0]  mean_overshoot;
    logic [TIME_BITS-1:0]  most_overshoot;
  } fts_snap_t;

  typedef struct packed {
    logic      capture;
    logic      over;
    logic      accum;
    logic      div_load;
    logic      div_step;
    logic      div_store;
    mean_sel_e sel;
    logic      snap;
  } fts_cmd_t;

  typedef struct packed {
    logic flush;
    logic out_busy;
  } fts_stat_t;

endpackage

// ----- design/fts_frame_if.sv -----
// fts_frame_if: valid/ready channel carrying one frame record per beat
// depends on fts_pkg for field widths
interface fts_frame_if;
  logic                            valid;
  logic                            ready;
  logic [fts_pkg::TIME_BITS-1:0]   pre_elapsed;
  logic [fts_pkg::TIME_BITS-1:0]   final_elapsed;
  logic [fts_pkg::SLEEP_BITS-1:0]  slept_ms;
  logic [fts_pkg::TIME_BITS-1:0]   target_interval;

  modport source (output valid, pre_elapsed, final_elapsed, slept_ms, target_interval,
                  input ready);
  modport sink   (input valid, pre_elapsed, final_elapsed, slept_ms, target_interval,
                  output ready);
  modport mon    (input valid, ready, pre_elapsed, final_elapsed, slept_ms, target_interval);
endinterface

// ----- design/fts_snap_if.sv -----
// fts_snap_if: valid/ready channel carrying one statistics snapshot per beat
// depends on fts_pkg for field widths
interface fts_snap_if;
  logic                            valid;
  logic                            ready;
  logic [fts_pkg::COUNT_BITS-1:0]  frames_seen;
  logic [fts_pkg::COUNT_BITS-1:0]  frames_slept;
  logic [fts_pkg::COUNT_BITS-1:0]  frames_late;
  logic [fts_pkg::TIME_BITS-1:0]   mean_pre;
  logic [fts_pkg::TIME_BITS-1:0]   mean_final;
  logic [fts_pkg::TIME_BITS-1:0]   least_final;
  logic [fts_pkg::TIME_BITS-1:0]   most_final;
  logic [fts_pkg::SLEEP_BITS-1:0]  mean_sleep;
  logic [fts_pkg::TIME_BITS-1:0]   mean_overshoot;
  logic [fts_pkg::TIME_BITS-1:0]   most_overshoot;

  modport source (output valid, frames_seen, frames_slept, frames_late, mean_pre, mean_final,
                  least_final, most_final, mean_sleep, mean_overshoot, most_overshoot,
                  input ready);
  modport sink   (input valid, frames_seen, frames_slept, frames_late, mean_pre, mean_final,
                  least_final, most_final, mean_sleep, mean_overshoot, most_overshoot,
                  output ready);
  modport mon    (input valid, ready, frames_seen, frames_slept, frames_late, mean_pre,
                  mean_final, least_final, most_final, mean_sleep, mean_overshoot,
                  most_overshoot);
endinterface

// ----- design/fts_ctrl.sv -----
// fts_ctrl: sequencer for frame intake, accumulation and the snapshot divisions
// depends on fts_pkg for command and status structs
module fts_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  fts_pkg::fts_stat_t stat_i,
  output fts_pkg::fts_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OVER,
    ST_ACC,
    ST_CHECK,
    ST_LOAD,
    ST_RUN,
    ST_STORE,
    ST_SNAP
  } state_e;

  state_e                            state_q;
  fts_pkg::mean_sel_e                sel_q;
  logic [fts_pkg::STEP_BITS-1:0]     step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q   <= fts_pkg::MEAN_PRE;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_OVER;
        end
        ST_OVER: begin
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          if (stat_i.flush) begin
            state_q <= ST_LOAD;
            sel_q   <= fts_pkg::MEAN_PRE;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_LOAD: begin
          step_q  <= '0;
          state_q <= ST_RUN;
        end
        ST_RUN: begin
          if (step_q == fts_pkg::STEP_BITS'(fts_pkg::SUM_BITS - 1)) begin
            state_q <= ST_STORE;
          end else begin
            step_q <= step_q + fts_pkg::STEP_BITS'(1);
          end
        end
        ST_STORE: begin
          if (sel_q == fts_pkg::MEAN_OVER) begin
            state_q <= ST_SNAP;
          end else begin
            sel_q   <= fts_pkg::mean_sel_e'(sel_q + 2'd1);
            state_q <= ST_LOAD;
          end
        end
        ST_SNAP: begin
          if (!stat_i.out_busy) state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o           = '0;
    cmd_o.capture   = in_ready_o && in_valid_i;
    cmd_o.over      = (state_q == ST_OVER);
    cmd_o.accum     = (state_q == ST_ACC);
    cmd_o.div_load  = (state_q == ST_LOAD);
    cmd_o.div_step  = (state_q == ST_RUN);
    cmd_o.div_store = (state_q == ST_STORE);
    cmd_o.sel       = sel_q;
    cmd_o.snap      = (state_q == ST_SNAP) && !stat_i.out_busy;
  end

endmodule

// ----- design/fts_dp.sv -----
// fts_dp: configuration, accumulators, shared serial divider and snapshot output register
// depends on fts_pkg for widths, codes and structs
module fts_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fts_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [fts_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  fts_pkg::fts_frame_t                 frame_i,
  input  fts_pkg::fts_cmd_t                   cmd_i,
  output fts_pkg::fts_stat_t                  stat_o,
  output fts_pkg::fts_snap_t                  snap_o,
  output logic                                snap_valid_o,
  input  logic                                snap_ready_i
);

  localparam int TB = fts_pkg::TIME_BITS;
  localparam int CB = fts_pkg::COUNT_BITS;
  localparam int SB = fts_pkg::SUM_BITS;

  logic [CB-1:0]                         flush_q;
  logic [fts_pkg::THRESH_BITS-1:0]       thresh_q;

  fts_pkg::fts_frame_t                   rec_q;
  logic [TB-1:0]                         over_q;
  logic                                  late_q;
  logic                                  slept_q;

  logic [CB-1:0]                         cnt_q;
  logic [CB-1:0]                         slept_cnt_q;
  logic [CB-1:0]                         late_cnt_q;
  logic [SB-1:0]                         pre_sum_q;
  logic [SB-1:0]                         fin_sum_q;
  logic [fts_pkg::SLEEP_SUM_BITS-1:0]    slp_sum_q;
  logic [SB-1:0]                         over_sum_q;
  logic [TB-1:0]                         fin_min_q;
  logic [TB-1:0]                         fin_max_q;
  logic [TB-1:0]                         over_max_q;

  logic [SB-1:0]                         dvd_q;
  logic [CB-1:0]                         rem_q;
  logic [TB-1:0]                         mean_pre_q;
  logic [TB-1:0]                         mean_fin_q;
  logic [fts_pkg::SLEEP_BITS-1:0]        mean_slp_q;
  logic [TB-1:0]                         mean_over_q;

  fts_pkg::fts_snap_t                    out_q;
  logic                                  out_valid_q;

  logic                                  cfg_hit;
  logic                                  clear;
  logic [TB-1:0]                         over_d;
  logic [SB-1:0]                         dvd_src;
  logic [CB:0]                           rem_sh;
  logic [CB:0]                           rem_diff;
  logic                                  ge;

  assign cfg_hit = cfg_we_i && ((cfg_idx_i == fts_pkg::CFG_FLUSH) ||
                                (cfg_idx_i == fts_pkg::CFG_THRESH));
  assign clear   = cfg_hit || cmd_i.snap;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flush_q  <= fts_pkg::FLUSH_RESET;
      thresh_q <= fts_pkg::THRESH_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == fts_pkg::CFG_FLUSH) begin
        flush_q <= (cfg_data_i[CB-1:0] == '0) ? CB'(1) : cfg_data_i[CB-1:0];
      end
      if (cfg_idx_i == fts_pkg::CFG_THRESH) begin
        thresh_q <= cfg_data_i[fts_pkg::THRESH_BITS-1:0];
      end
    end
  end

  // overshoot stage
  assign over_d = (rec_q.final_elapsed > rec_q.target_interval) ?
                  (rec_q.final_elapsed - rec_q.target_interval) : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) rec_q <= frame_i;
    if (cmd_i.over) begin
      over_q  <= over_d;
      late_q  <= fts_pkg::THRESH_BITS'(over_d) > thresh_q;
      slept_q <= (rec_q.slept_ms != '0);
    end
  end

  // accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      slept_cnt_q <= '0;
      late_cnt_q  <= '0;
      pre_sum_q   <= '0;
      fin_sum_q   <= '0;
      slp_sum_q   <= '0;
      over_sum_q  <= '0;
      fin_min_q   <= '1;
      fin_max_q   <= '0;
      over_max_q  <= '0;
    end else if (clear) begin
      cnt_q       <= '0;
      slept_cnt_q <= '0;
      late_cnt_q  <= '0;
      pre_sum_q   <= '0;
      fin_sum_q   <= '0;
      slp_sum_q   <= '0;
      over_sum_q  <= '0;
      fin_min_q   <= '1;
      fin_max_q   <= '0;
      over_max_q  <= '0;
    end else if (cmd_i.accum) begin
      cnt_q      <= cnt_q + CB'(1);
      pre_sum_q  <= pre_sum_q + SB'(rec_q.pre_elapsed);
      fin_sum_q  <= fin_sum_q + SB'(rec_q.final_elapsed);
      slp_sum_q  <= slp_sum_q + fts_pkg::SLEEP_SUM_BITS'(rec_q.slept_ms);
      over_sum_q <= over_sum_q + SB'(over_q);
      if (slept_q) slept_cnt_q <= slept_cnt_q + CB'(1);
      if (late_q) late_cnt_q <= late_cnt_q + CB'(1);
      if (rec_q.final_elapsed < fin_min_q) fin_min_q <= rec_q.final_elapsed;
      if (rec_q.final_elapsed > fin_max_q) fin_max_q <= rec_q.final_elapsed;
      if (over_q > over_max_q) over_max_q <= over_q;
    end
  end

  // restoring divider, one quotient bit per cycle, divisor is the frame count
  always_comb begin
    unique case (cmd_i.sel)
      fts_pkg::MEAN_PRE:   dvd_src = pre_sum_q;
      fts_pkg::MEAN_FINAL: dvd_src = fin_sum_q;
      fts_pkg::MEAN_SLEEP: dvd_src = SB'(slp_sum_q);
      fts_pkg::MEAN_OVER:  dvd_src = over_sum_q;
    endcase
  end

  assign rem_sh   = {rem_q, dvd_q[SB-1]};
  assign ge       = rem_sh >= {1'b0, cnt_q};
  assign rem_diff = rem_sh - {1'b0, cnt_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      dvd_q <= dvd_src;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[SB-2:0], ge};
      rem_q <= ge ? rem_diff[CB-1:0] : rem_sh[CB-1:0];
    end
    if (cmd_i.div_store) begin
      unique case (cmd_i.sel)
        fts_pkg::MEAN_PRE:   mean_pre_q  <= dvd_q[TB-1:0];
        fts_pkg::MEAN_FINAL: mean_fin_q  <= dvd_q[TB-1:0];
        fts_pkg::MEAN_SLEEP: mean_slp_q  <= dvd_q[fts_pkg::SLEEP_BITS-1:0];
        fts_pkg::MEAN_OVER:  mean_over_q <= dvd_q[TB-1:0];
      endcase
    end
  end

  // snapshot output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.snap) begin
      out_q.frames_seen    <= cnt_q;
      out_q.frames_slept   <= slept_cnt_q;
      out_q.frames_late    <= late_cnt_q;
      out_q.mean_pre       <= mean_pre_q;
      out_q.mean_final     <= mean_fin_q;
      out_q.least_final    <= fin_min_q;
      out_q.most_final     <= fin_max_q;
      out_q.mean_sleep     <= mean_slp_q;
      out_q.mean_overshoot <= mean_over_q;
      out_q.most_overshoot <= over_max_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.snap) begin
      out_valid_q <= 1'b1;
    end else if (snap_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.flush    = (cnt_q >= flush_q) || (cnt_q == '1);
  assign stat_o.out_busy = out_valid_q;
  assign snap_o          = out_q;
  assign snap_valid_o    = out_valid_q;

endmodule

// ----- design/frame_timing_stats_unit.sv -----
// frame_timing_stats_unit: top level of the frame timing statistics unit
// depends on fts_pkg, fts_frame_if, fts_snap_if, fts_ctrl and fts_dp
//
// One frame record is taken per beat on frame_i; an ordinary frame occupies the unit for
// intake, overshoot, accumulate and flush check, as set by the sequencer in fts_ctrl.
// A frame that completes a snapshot then needs the four means, which go one after the other
// through one shared restoring divider that yields one quotient bit per cycle. The snapshot
// then sits in an output register, so further frames are taken while it waits on snap_o;
// only the next snapshot waits for it. Configuration writes clear all accumulators and
// take effect at once; there is no clearing pass after reset.
module frame_timing_stats_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  fts_frame_if.sink                           frame_i,
  fts_snap_if.source                          snap_o,
  input  logic                                cfg_we_i,
  input  logic [fts_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [fts_pkg::CFG_DATA_BITS-1:0]   cfg_data_i
);

  fts_pkg::fts_frame_t frame;
  fts_pkg::fts_snap_t  snap;
  fts_pkg::fts_cmd_t   cmd;
  fts_pkg::fts_stat_t  stat;
  logic                in_ready;
  logic                snap_valid;

  assign frame.pre_elapsed     = frame_i.pre_elapsed;
  assign frame.final_elapsed   = frame_i.final_elapsed;
  assign frame.slept_ms        = frame_i.slept_ms;
  assign frame.target_interval = frame_i.target_interval;
  assign frame_i.ready         = in_ready;

  fts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (frame_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fts_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .frame_i      (frame),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .snap_o       (snap),
    .snap_valid_o (snap_valid),
    .snap_ready_i (snap_o.ready)
  );

  assign snap_o.valid          = snap_valid;
  assign snap_o.frames_seen    = snap.frames_seen;
  assign snap_o.frames_slept   = snap.frames_slept;
  assign snap_o.frames_late    = snap.frames_late;
  assign snap_o.mean_pre       = snap.mean_pre;
  assign snap_o.mean_final     = snap.mean_final;
  assign snap_o.least_final    = snap.least_final;
  assign snap_o.most_final     = snap.most_final;
  assign snap_o.mean_sleep     = snap.mean_sleep;
  assign snap_o.mean_overshoot = snap.mean_overshoot;
  assign snap_o.most_overshoot = snap.most_overshoot;

endmodule

// ----- design/fts_checker.sv -----
// fts_checker: port-level assertions for frame_timing_stats_unit, bound to the top level
// depends on fts_pkg for field widths
module fts_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            frame_valid_i,
  input logic                            frame_ready_i,
  input logic                            snap_valid_i,
  input logic                            snap_ready_i,
  input logic [fts_pkg::COUNT_BITS-1:0]  frames_seen_i,
  input logic [fts_pkg::COUNT_BITS-1:0]  frames_slept_i,
  input logic [fts_pkg::COUNT_BITS-1:0]  frames_late_i,
  input logic [fts_pkg::TIME_BITS-1:0]   mean_final_i,
  input logic [fts_pkg::TIME_BITS-1:0]   least_final_i,
  input logic [fts_pkg::TIME_BITS-1:0]   most_final_i,
  input logic [fts_pkg::SLEEP_BITS-1:0]  mean_sleep_i,
  input logic [fts_pkg::TIME_BITS-1:0]   mean_overshoot_i,
  input logic [fts_pkg::TIME_BITS-1:0]   most_overshoot_i
);

  // stalled snapshot beat holds
  a_snap_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_valid_i && !snap_ready_i |=>
      snap_valid_i && $stable(frames_seen_i) && $stable(mean_final_i) &&
      $stable(most_overshoot_i) && $stable(mean_sleep_i))
    else $error("snapshot changed while stalled");

  // one frame at a time
  a_one_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_valid_i && frame_ready_i |=> !frame_ready_i)
    else $error("frame taken while previous still in work");

  a_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_valid_i |-> (frames_seen_i != '0) &&
      (frames_slept_i <= frames_seen_i) &&
      (frames_late_i <= frames_seen_i))
    else $error("snapshot counts inconsistent");

  a_final_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_valid_i |-> (least_final_i <= most_final_i) &&
      (mean_final_i >= least_final_i) &&
      (mean_final_i <= most_final_i) &&
      (mean_overshoot_i <= most_overshoot_i))
    else $error("snapshot mean outside min/max");

endmodule

bind frame_timing_stats_unit fts_checker u_fts_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .frame_valid_i    (frame_i.valid),
  .frame_ready_i    (frame_i.ready),
  .snap_valid_i     (snap_o.valid),
  .snap_ready_i     (snap_o.ready),
  .frames_seen_i    (snap_o.frames_seen),
  .frames_slept_i   (snap_o.frames_slept),
  .frames_late_i    (snap_o.frames_late),
  .mean_final_i     (snap_o.mean_final),
  .least_final_i    (snap_o.least_final),
  .most_final_i     (snap_o.most_final),
  .mean_sleep_i     (snap_o.mean_sleep),
  .mean_overshoot_i (snap_o.mean_overshoot),
  .most_overshoot_i (snap_o.most_overshoot)
);
